// ===== rtl/solenoid_strike_hold_sequencer_unit_assert.svh =====
// assertion macros for the solenoid sequencer, clocked on clk, off during reset
`ifndef SOLENOID_STRIKE_HOLD_SEQUENCER_UNIT_ASSERT_SVH
`define SOLENOID_STRIKE_HOLD_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define SSHS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sshs same-cycle check failed");

// next-cycle implication
`define SSHS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sshs next-cycle check failed");

`endif

// ===== rtl/sshs_pkg.sv =====
`timescale 1ns / 1ps
package sshs_pkg;

  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam int unsigned KEY_W        = 6;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned DUTY_W       = 7;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned NOW_W        = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  localparam logic [DUTY_W-1:0] HOLD_DUTY_RST      = 7'd30;
  localparam logic [TIME_W-1:0] DEFAULT_STRIKE_RST = 16'd100;
  localparam logic [CNT_W-1:0]  KEY_COUNT_RST      = 7'd64;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STRIKE = 2'd1,
    PH_FOLLOW = 2'd2,
    PH_HOLD   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_HOLD_DUTY      = 2'd0,
    REG_DEFAULT_STRIKE = 2'd1,
    REG_KEY_COUNT      = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMD,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    phase_t              phase;
    logic [NOW_W-1:0]    start;
    logic [TIME_W-1:0]   strike_len;
    logic [DUTY_W-1:0]   follow_duty;
    logic [TIME_W-1:0]   follow_len;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [KEY_W-1:0]  addr;
    entry_t            data;
  } mem_wr_t;

  typedef struct packed {
    logic [DUTY_W-1:0] hold_duty;
    logic [TIME_W-1:0] default_strike;
    logic [CNT_W-1:0]  keys_used;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DUTY_W-1:0] duty;
    phase_t            phase;
    logic              last;
  } result_t;

  function automatic logic [DUTY_W-1:0] clamp_duty(input logic [7:0] d);
    logic [DUTY_W-1:0] r;
    r = (d > {1'b0, DUTY_MAX}) ? DUTY_MAX : d[DUTY_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/sshs_mem.sv =====
`timescale 1ns / 1ps
module sshs_mem #(
  parameter int unsigned MAX_KEYS = sshs_pkg::MAX_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sshs_pkg::mem_wr_t          wr,
  input  logic                       rd_en,
  input  logic [sshs_pkg::KEY_W-1:0] rd_addr,
  output sshs_pkg::entry_t           rd_data
);
  import sshs_pkg::*;

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  entry_t              mem_r [MAX_KEYS];
  logic [MAX_KEYS-1:0] written_r;
  entry_t              q_r;
  logic                q_written_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      q_r         <= mem_r[rd_addr[AW-1:0]];
      q_written_r <= written_r[rd_addr[AW-1:0]];
    end
  end

  // entries never written since reset read back as idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr.en) begin
      written_r[wr.addr[AW-1:0]] <= 1'b1;
    end
  end

  always_comb begin
    rd_data = q_r;
    if (!q_written_r) begin
      rd_data.phase = PH_IDLE;
    end
  end

endmodule

// ===== rtl/sshs_seq.sv =====
`timescale 1ns / 1ps
module sshs_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [sshs_pkg::KEY_W-1:0]  in_key_index,
  input  logic [7:0]                  in_strike_duty,
  input  logic [sshs_pkg::TIME_W-1:0] in_strike_time,
  input  logic [7:0]                  in_followup_duty,
  input  logic [sshs_pkg::TIME_W-1:0] in_followup_time,
  input  sshs_pkg::cfg_t              cfg,
  output sshs_pkg::mem_wr_t           wr,
  output logic                        rd_en,
  output logic [sshs_pkg::KEY_W-1:0]  rd_addr,
  input  sshs_pkg::entry_t            rd_data,
  output sshs_pkg::result_t           res,
  output logic                        res_strobe
);
  import sshs_pkg::*;

  state_t            state_r, state_nxt;
  logic [NOW_W-1:0]  now_ms_r;
  entry_t            req_entry_r;
  logic [KEY_W-1:0]  req_key_r;
  logic [DUTY_W-1:0] req_duty_r;
  logic [CNT_W-1:0]  rd_idx_r;
  logic              ev_vld_r;
  logic [KEY_W-1:0]  ev_key_r;
  logic              pend_vld_r;
  result_t           pend_r;
  result_t           res_r;
  logic              res_strobe_r;

  logic              accept;
  logic              key_ok;
  logic [NOW_W-1:0]  elapsed;
  entry_t            upd;
  logic              hit;
  logic [DUTY_W-1:0] hit_duty;

  assign accept  = start && (state_r == ST_IDLE);
  assign key_ok  = {1'b0, in_key_index} < cfg.keys_used;
  assign busy    = (state_r != ST_IDLE);
  assign rd_addr = rd_idx_r[KEY_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PRESS, CMD_RELEASE: state_nxt = key_ok ? ST_CMD : ST_IDLE;
            CMD_TICK:               state_nxt = ST_WALK;
            default:                state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CMD:   state_nxt = ST_IDLE;
      ST_WALK:  state_nxt = (!rd_en && !ev_vld_r) ? ST_FLUSH : ST_WALK;
      ST_FLUSH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // phase step of the key whose entry came back from memory this cycle
  always_comb begin
    elapsed  = now_ms_r - rd_data.start;
    upd      = rd_data;
    hit      = 1'b0;
    hit_duty = cfg.hold_duty;
    if (ev_vld_r) begin
      case (rd_data.phase)
        PH_STRIKE: begin
          if (elapsed >= {{(NOW_W-TIME_W){1'b0}}, rd_data.strike_len}) begin
            hit = 1'b1;
            if (rd_data.follow_duty != '0 && rd_data.follow_len != '0) begin
              upd.phase = PH_FOLLOW;
              upd.start = now_ms_r;
              hit_duty  = rd_data.follow_duty;
            end else begin
              upd.phase = PH_HOLD;
            end
          end
        end
        PH_FOLLOW: begin
          if (elapsed >= {{(NOW_W-TIME_W){1'b0}}, rd_data.follow_len}) begin
            hit       = 1'b1;
            upd.phase = PH_HOLD;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_en = 1'b0;
    wr    = '0;
    unique case (state_r)
      ST_CMD: begin
        wr.en   = 1'b1;
        wr.addr = req_key_r;
        wr.data = req_entry_r;
      end
      ST_WALK: begin
        rd_en   = (rd_idx_r < cfg.keys_used);
        wr.en   = hit;
        wr.addr = ev_key_r;
        wr.data = upd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      now_ms_r     <= '0;
      ev_vld_r     <= 1'b0;
      pend_vld_r   <= 1'b0;
      res_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ev_vld_r     <= rd_en;
      if (accept && in_cmd == CMD_TICK) begin
        now_ms_r <= now_ms_r + 1'b1;
      end
      case (state_r)
        ST_CMD: res_strobe_r <= 1'b1;
        ST_WALK: begin
          res_strobe_r <= hit && pend_vld_r;
          if (hit) begin
            pend_vld_r <= 1'b1;
          end
        end
        ST_FLUSH: begin
          res_strobe_r <= pend_vld_r;
          pend_vld_r   <= 1'b0;
        end
        default: res_strobe_r <= 1'b0;
      endcase
    end
  end

  // a found transition waits in pend_r until the next one shows it was not the last
  always_ff @(posedge clk) begin
    if (accept) begin
      req_key_r              <= in_key_index;
      req_entry_r.phase      <= (in_cmd == CMD_PRESS) ? PH_STRIKE : PH_IDLE;
      req_entry_r.start      <= now_ms_r;
      req_entry_r.strike_len <= (in_strike_time != '0) ? in_strike_time : cfg.default_strike;
      req_entry_r.follow_duty <= clamp_duty(in_followup_duty);
      req_entry_r.follow_len <= in_followup_time;
      req_duty_r             <= (in_cmd == CMD_PRESS) ? clamp_duty(in_strike_duty) : '0;
      rd_idx_r               <= '0;
    end else if (rd_en) begin
      rd_idx_r <= rd_idx_r + 1'b1;
    end
    ev_key_r <= rd_idx_r[KEY_W-1:0];
    case (state_r)
      ST_CMD: begin
        res_r.key   <= req_key_r;
        res_r.duty  <= req_duty_r;
        res_r.phase <= req_entry_r.phase;
        res_r.last  <= 1'b1;
      end
      ST_WALK: begin
        if (hit) begin
          res_r        <= pend_r;
          pend_r.key   <= ev_key_r;
          pend_r.duty  <= hit_duty;
          pend_r.phase <= upd.phase;
          pend_r.last  <= 1'b0;
        end
      end
      ST_FLUSH: begin
        res_r.key   <= pend_r.key;
        res_r.duty  <= pend_r.duty;
        res_r.phase <= pend_r.phase;
        res_r.last  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign res        = res_r;
  assign res_strobe = res_strobe_r;

endmodule

// ===== rtl/solenoid_strike_hold_sequencer_unit.sv =====
`timescale 1ns / 1ps
// channel   ports                                              handshake
// input     in_cmd in_key_index in_strike_duty in_strike_time  start, busy
//           in_followup_duty in_followup_time
// result    out_key out_duty out_new_phase out_last            out_strobe, one cycle
// config    cfg_index cfg_data                                 cfg_valid, cfg_ready
//
// press or release of a used key: entry written while busy, result as busy drops.
// tick: busy while the keys are walked, one key entry read from the state
//   memory per cycle; each transition is held until the next one is found, and the
//   last result comes in the same cycle that busy drops.
// synchronous active-low reset clears the per-key written flags, so every key starts
//   idle at once with no clearing pass; the millisecond counter resets to zero.
// the receiver cannot stall: each result is shown for exactly one cycle.
module solenoid_strike_hold_sequencer_unit #(
  parameter int unsigned MAX_KEYS = sshs_pkg::MAX_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_cmd,
  input  logic [sshs_pkg::KEY_W-1:0]      in_key_index,
  input  logic [7:0]                      in_strike_duty,
  input  logic [sshs_pkg::TIME_W-1:0]     in_strike_time,
  input  logic [7:0]                      in_followup_duty,
  input  logic [sshs_pkg::TIME_W-1:0]     in_followup_time,
  output logic                            out_strobe,
  output logic [sshs_pkg::KEY_W-1:0]      out_key,
  output logic [sshs_pkg::DUTY_W-1:0]     out_duty,
  output logic [1:0]                      out_new_phase,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sshs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sshs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sshs_pkg::*;

  localparam logic [CNT_W-1:0] KEYS_MAX = CNT_W'(MAX_KEYS);

  logic [DUTY_W-1:0] hold_duty_r;
  logic [TIME_W-1:0] default_strike_r;
  logic [CNT_W-1:0]  key_count_r;
  cfg_t              cfg;
  mem_wr_t           wr;
  logic              rd_en;
  logic [KEY_W-1:0]  rd_addr;
  entry_t            rd_data;
  result_t           res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_duty_r      <= HOLD_DUTY_RST;
      default_strike_r <= DEFAULT_STRIKE_RST;
      key_count_r      <= KEY_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOLD_DUTY:      hold_duty_r      <= cfg_data[DUTY_W-1:0];
        REG_DEFAULT_STRIKE: default_strike_r <= cfg_data[TIME_W-1:0];
        REG_KEY_COUNT:      key_count_r      <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.hold_duty      = (hold_duty_r > DUTY_MAX) ? DUTY_MAX : hold_duty_r;
  assign cfg.default_strike = default_strike_r;
  assign cfg.keys_used      = (key_count_r > KEYS_MAX) ? KEYS_MAX : key_count_r;

  sshs_mem #(
    .MAX_KEYS(MAX_KEYS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sshs_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_key_index     (in_key_index),
    .in_strike_duty   (in_strike_duty),
    .in_strike_time   (in_strike_time),
    .in_followup_duty (in_followup_duty),
    .in_followup_time (in_followup_time),
    .cfg              (cfg),
    .wr               (wr),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .res              (res),
    .res_strobe       (out_strobe)
  );

  assign out_key       = res.key;
  assign out_duty      = res.duty;
  assign out_new_phase = res.phase;
  assign out_last      = res.last;

`include "solenoid_strike_hold_sequencer_unit_assert.svh"

  // results only follow work, never an idle cycle
  `SSHS_ASSERT_NXT(a_no_result_from_idle, !busy, !out_strobe)
  // nothing follows the final result of a request
  `SSHS_ASSERT_NXT(a_last_ends_request, out_strobe && out_last, !out_strobe)
  `SSHS_ASSERT_IMP(a_duty_in_range, out_strobe, out_duty <= DUTY_MAX)
  // the state memory is never read and written at the same key
  `SSHS_ASSERT_IMP(a_no_rw_overlap, rd_en && wr.en, rd_addr != wr.addr)

endmodule
